### rtl/euclidean_distance_defines.svh
// ----------------------------------------------------------------------------
// Euclidean distance assertion macros
// Shared property templates for the distance block's port checker.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define ED_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define ED_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ed_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean distance package
// Widths, the square-root step count and the type carried along the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ed_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int SUM_BITS       = 64;
    localparam int DIST_BITS      = 32;
    // One result bit is settled in each cell of the root row.
    localparam int SQRT_STEPS     = SUM_BITS / 2;

    typedef struct packed {
        logic [SUM_BITS-1:0] rem;
        logic [SUM_BITS-1:0] root;
        logic                sat;
    } t_sqrt_st;

endpackage

### rtl/ed_accum.sv
// ----------------------------------------------------------------------------
// Squared-difference accumulator
// Absolute difference, square and saturating 64-bit sum of a vector's beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ed_accum
    import ed_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_coord_a,
    input  logic [COORD_BITS-1:0] i_coord_b,
    input  logic                  i_last,
    output logic                  o_valid,
    output t_sqrt_st              o_st
);

    logic signed [COORD_BITS:0]   w_diff;
    logic        [COORD_BITS-1:0] w_abs;
    logic        [SUM_BITS:0]     w_total;
    logic        [SUM_BITS-1:0]   w_sum_sat;
    logic                         w_ovf;

    logic                         r_d_valid;
    logic                         r_d_last;
    logic [COORD_BITS-1:0]        r_diff;
    logic                         r_q_valid;
    logic                         r_q_last;
    logic [2*COORD_BITS-1:0]      r_sq;
    logic [SUM_BITS-1:0]          r_sum;
    logic                         r_ovf;

    assign w_diff = $signed({i_coord_a[COORD_BITS-1], i_coord_a})
                  - $signed({i_coord_b[COORD_BITS-1], i_coord_b});
    // The magnitude of a difference of two COORD_BITS values always fits COORD_BITS bits.
    assign w_abs  = w_diff[COORD_BITS] ? COORD_BITS'(-w_diff) : w_diff[COORD_BITS-1:0];

    assign w_total   = {1'b0, r_sum} + {1'b0, SUM_BITS'(r_sq)};
    assign w_sum_sat = w_total[SUM_BITS] ? {SUM_BITS{1'b1}} : w_total[SUM_BITS-1:0];
    assign w_ovf     = r_ovf | w_total[SUM_BITS];

    always_ff @(posedge i_clk) begin
        r_diff <= w_abs;
        r_sq   <= r_diff * r_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_d_last  <= 1'b0;
            r_q_valid <= 1'b0;
            r_q_last  <= 1'b0;
            r_sum     <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_d_valid <= i_valid;
            r_d_last  <= i_last;
            r_q_valid <= r_d_valid;
            r_q_last  <= r_d_last;
            if (r_q_valid) begin
                if (r_q_last) begin
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_sum <= w_sum_sat;
                    r_ovf <= w_ovf;
                end
            end
        end
    end

    assign o_valid     = r_q_valid & r_q_last;
    assign o_st.rem    = w_sum_sat;
    assign o_st.root   = '0;
    assign o_st.sat    = w_ovf;

endmodule

### rtl/ed_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square-root cell
// One restoring step of the integer square root, registered toward the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ed_sqrt_cell
    import ed_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_sqrt_st i_st,
    output logic     o_valid,
    output t_sqrt_st o_st
);

    localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * STEP);

    logic [SUM_BITS-1:0] w_trial;
    t_sqrt_st            n_st;
    logic                r_valid;
    t_sqrt_st            r_st;

    assign w_trial = i_st.root + BIT;

    always_comb begin
        n_st     = i_st;
        if (i_st.rem >= w_trial) begin
            n_st.rem  = i_st.rem - w_trial;
            n_st.root = (i_st.root >> 1) + BIT;
        end else begin
            n_st.root = i_st.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

### rtl/euclidean_distance.sv
// ----------------------------------------------------------------------------
// Euclidean distance
// Streams coordinate pairs, sums squared differences and emits the floor root.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Content
//  s_axis   | in        | coord_a, coord_b in tdata; last_dim on tlast
//  m_axis   | out       | distance in tdata; saturated on tuser
//
//  A beat that is not the last of a vector is taken every cycle. After the last
//  beat, s_axis_tready stays low while the sum passes the two accumulator
//  stages and the 32-cell root row, until the result loads into the output
//  register. Reset is synchronous and clears the sum and all valid flags. A
//  stalled result holds in the output register and freezes the root row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euclidean_distance
    import ed_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // coord_a [COORD_BITS-1:0], coord_b [2*COORD_BITS-1:COORD_BITS], zero fill
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // distance [31:0]
    output logic [DIST_BITS-1:0] m_axis_tdata,
    // saturated [0]
    output logic [0:0]           m_axis_tuser
);

    logic                 w_accept;
    logic                 w_stall;
    logic                 w_load;
    logic                 w_vld [SQRT_STEPS+1];
    t_sqrt_st             w_st  [SQRT_STEPS+1];

    logic                 r_busy;
    logic                 r_out_valid;
    logic [DIST_BITS-1:0] r_dist;
    logic                 r_sat;

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid & !r_busy;

    ed_accum #(
        .COORD_BITS (COORD_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_coord_a (s_axis_tdata[COORD_BITS-1:0]),
        .i_coord_b (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_last    (s_axis_tlast),
        .o_valid   (w_vld[0]),
        .o_st      (w_st[0])
    );

    // Only one vector is ever in the row, so the whole row may freeze together.
    assign w_stall = w_vld[SQRT_STEPS] & r_out_valid & !m_axis_tready;
    assign w_load  = w_vld[SQRT_STEPS] & !w_stall;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
        ed_sqrt_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (!w_stall),
            .i_valid (w_vld[g]),
            .i_st    (w_st[g]),
            .o_valid (w_vld[g+1]),
            .o_st    (w_st[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dist <= w_st[SQRT_STEPS].root[DIST_BITS-1:0];
            r_sat  <= w_st[SQRT_STEPS].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && s_axis_tlast) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_dist;
    assign m_axis_tuser  = r_sat;

endmodule

### rtl/ed_checker.sv
// ----------------------------------------------------------------------------
// Euclidean distance port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euclidean_distance_defines.svh"

module ed_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser
);

    // A stalled result must hold still.
    `ED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // The last beat of a vector closes the input until its result is out.
    `ED_ASSERT_NEXT(a_last_blocks, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input open after the last beat")

    // A saturated sum always roots to the largest distance.
    `ED_ASSERT_IMPL(a_sat_max, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'hFFFF_FFFF, "saturated result below the maximum")

    // Reset empties the output register.
    `ED_ASSERT_NEXT_RST(a_rst_clear, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind euclidean_distance ed_checker u_ed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/tb_euclidean_distance.sv
// ----------------------------------------------------------------------------
// Euclidean distance testbench
// Streams coordinate pairs into the block. A scoreboard keeps its own running
// sum of squared differences and works out the floor square root of each
// vector. Every distance beat is compared field by field with the oldest
// expected result. Both handshake sides idle and stall at random in phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euclidean_distance;
    import ed_pkg::*;

    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int WATCHDOG   = 4000;
    localparam int HOLD_BEATS = 400;
    localparam int RAND_ITEMS = 912;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 sat;
    } t_dist_result;

    class dist_scoreboard;
        logic [SUM_BITS-1:0] sum_sq;
        bit                  sat_seen;
        t_dist_result        pending[$];
        int                  errors;
        int                  checked;

        function new();
            sum_sq   = '0;
            sat_seen = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        function logic [DIST_BITS-1:0] floor_sqrt(logic [SUM_BITS-1:0] x);
            logic [DIST_BITS-1:0] root;
            logic [DIST_BITS-1:0] trial;
            root = '0;
            for (int i = DIST_BITS - 1; i >= 0; i--) begin
                trial = root | (DIST_BITS'(1) << i);
                if (SUM_BITS'(trial) * SUM_BITS'(trial) <= x)
                    root = trial;
            end
            return root;
        endfunction

        function void note_beat(logic signed [COORD_BITS-1:0] a,
                                logic signed [COORD_BITS-1:0] b, bit last);
            longint              diff;
            logic [SUM_BITS:0]   wide;
            t_dist_result        res;
            diff = longint'(a) - longint'(b);
            if (diff < 0)
                diff = -diff;
            wide = {1'b0, sum_sq} + (SUM_BITS + 1)'(diff * diff);
            if (wide[SUM_BITS]) begin
                sum_sq   = '1;
                sat_seen = 1'b1;
            end else begin
                sum_sq = wide[SUM_BITS-1:0];
            end
            if (last) begin
                res.distance = floor_sqrt(sum_sq);
                res.sat      = sat_seen;
                pending.push_back(res);
                sum_sq   = '0;
                sat_seen = 1'b0;
            end
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [DIST_BITS-1:0] distance, logic sat);
            t_dist_result want;
            if (pending.size() == 0) begin
                report($sformatf("distance %0d arrived with nothing expected", distance));
            end else begin
                want = pending.pop_front();
                checked++;
                if (distance !== want.distance)
                    report($sformatf("distance %0d, expected %0d", distance,
                                     want.distance));
                if (sat !== want.sat)
                    report($sformatf("saturated %b, expected %b", sat, want.sat));
            end
        endtask
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // coord_a [COORD_BITS-1:0], coord_b [2*COORD_BITS-1:COORD_BITS], zero fill
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // distance [31:0]
    logic [DIST_BITS-1:0] m_axis_tdata;
    // saturated [0]
    logic [0:0]           m_axis_tuser;

    dist_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    bit hold_taken     = 1'b0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int beats_sent     = 0;

    euclidean_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls at random; a requested hold-off is counted down here.
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_BEATS;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_beat(s_axis_tdata[COORD_BITS-1:0],
                         s_axis_tdata[2*COORD_BITS-1:COORD_BITS], s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[%0t] watchdog: no beat moved for %0d cycles", $time, WATCHDOG);
            $display("tb_euclidean_distance: done, errors");
            $finish;
        end
    end

    task send_beat(logic [COORD_BITS-1:0] a, logic [COORD_BITS-1:0] b, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({b, a});
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    function logic [COORD_BITS-1:0] rand_coord();
        logic [31:0] r;
        int          v;
        r = $urandom();
        v = int'($urandom_range(32)) - 16;
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return v[COORD_BITS-1:0];
            default: return r[COORD_BITS-1:0];
        endcase
    endfunction

    task send_random_vector();
        int len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(6, 1);
        else if (pick < 95)
            len = $urandom_range(24, 7);
        else
            len = $urandom_range(64, 25);
        for (int i = 0; i < len; i++)
            send_beat(rand_coord(), rand_coord(), i == len - 1);
    endtask

    // The last beat is withdrawn so that it is not taken a second time.
    task wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    task run_phase(int idle_pct, int stall_pct, int n_beats);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = beats_sent + n_beats;
        while (beats_sent < target)
            send_random_vector();
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-beat vectors give the plain absolute difference.
        send_beat('0, '0, 1'b1);
        send_beat(COORD_MAX, COORD_MIN, 1'b1);
        send_beat(COORD_MIN, COORD_MAX, 1'b1);
        send_beat('1, 24'd1, 1'b1);
        send_beat(COORD_MIN, COORD_MIN, 1'b1);
        send_beat(COORD_MAX, COORD_MAX, 1'b1);
        // A 3-4-5 triangle, then a root that has to be rounded down.
        send_beat(24'd3, '0, 1'b0);
        send_beat('0, 24'd4, 1'b1);
        send_beat(24'd1, '0, 1'b0);
        send_beat('0, 24'd1, 1'b1);
        send_beat(COORD_MAX, COORD_MAX, 1'b0);
        send_beat(COORD_MIN, '0, 1'b1);
        wait_drained();

        run_phase(0, 0, RAND_ITEMS / 4);
        run_phase(55, 0, RAND_ITEMS / 4);
        run_phase(0, 55, RAND_ITEMS / 4);
        run_phase(31, 31, RAND_ITEMS / 4);

        // Long receiver hold-off while the sender keeps offering beats.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req      <= 1'b1;
        for (int v = 0; v < 12; v++)
            send_random_vector();
        wait_drained();

        repeat (40) @(posedge i_clk);
        while (sb.pending.size() != 0) begin
            sb.report("expected distance never arrived");
            void'(sb.pending.pop_front());
        end

        $display("Sent %0d coordinate beats and checked %0d distances, covering", beats_sent,
                 sb.checked);
        $display("idle and stall mixes and a long output hold-off.");
        if (sb.errors == 0) begin
            $display("tb_euclidean_distance: done, clean");
        end else begin
            $display("tb_euclidean_distance: done, errors");
        end
        $finish;
    end

endmodule
